// File: rtl/fixed_point_alu_assert.svh
// ----------------------------------------------------------------------------
// fixed_point_alu_assert
// Assertion macros shared by the fixed-point ALU modules.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// A condition that must lead to a consequence in the same cycle.
`define FPA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// A condition that must lead to a consequence in the next cycle.
`define FPA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Types, codes and widths shared by the fixed-point ALU modules.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DATA_W = 32;

    // Operation codes.
    localparam logic [3:0] MODE_ADD  = 4'd0;
    localparam logic [3:0] MODE_SUB  = 4'd1;
    localparam logic [3:0] MODE_MUL  = 4'd2;
    localparam logic [3:0] MODE_DIV  = 4'd3;
    localparam logic [3:0] MODE_MIN  = 4'd4;
    localparam logic [3:0] MODE_MAX  = 4'd5;
    localparam logic [3:0] MODE_INC  = 4'd6;
    localparam logic [3:0] MODE_DEC  = 4'd7;
    localparam logic [3:0] MODE_TOI  = 4'd8;
    localparam logic [3:0] MODE_FROMI = 4'd9;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    // Word as it leaves the front stage and the result as it leaves the end.
    // The layout matches the result word on m_tdata, lowest field last.
    typedef struct packed {
        logic [1:0]  status;
        logic        a_less;
        logic        a_equal;
        logic        a_greater;
        logic [31:0] result;
    } fpa_res_t;

    // Bookkeeping that moves down the divider chain with each word.
    typedef struct packed {
        logic     valid;
        logic     is_div;
        logic     neg;
        fpa_res_t res;
    } fpa_tag_t;

endpackage

// File: rtl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division step: brings in one dividend bit and makes one
// quotient bit, then registers everything for the next cell.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  fpa_pkg::fpa_tag_t    tag_in,
    input  logic [NUM_W-1:0]     num_in,
    input  logic [DEN_W-1:0]     den_in,
    input  logic [DEN_W:0]       rem_in,
    input  logic [NUM_W-1:0]     quo_in,
    output fpa_pkg::fpa_tag_t    tag_out,
    output logic [NUM_W-1:0]     num_out,
    output logic [DEN_W-1:0]     den_out,
    output logic [DEN_W:0]       rem_out,
    output logic [NUM_W-1:0]     quo_out
);
    import fpa_pkg::*;

    logic [DEN_W+1:0] trial;
    logic [DEN_W:0]   shifted;
    logic             take;

    // Shift in the next dividend bit and try a subtract.
    always_comb begin
        shifted = {rem_in[DEN_W-1:0], num_in[NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, den_in};
        take    = !trial[DEN_W+1];
    end

    // Only the valid bit is reset; the data follows it down the chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_out.valid <= 1'b0;
        end else if (en) begin
            tag_out.valid <= tag_in.valid;
        end
        if (en) begin
            tag_out.is_div <= tag_in.is_div;
            tag_out.neg    <= tag_in.neg;
            tag_out.res    <= tag_in.res;
            num_out        <= {num_in[NUM_W-2:0], 1'b0};
            den_out        <= den_in;
            rem_out        <= take ? trial[DEN_W:0] : shifted;
            quo_out        <= {quo_in[NUM_W-2:0], take};
        end
    end

endmodule

// File: rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// First stage: every operation except the quotient, registered once.
// Also prepares magnitudes for the division chain.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [3:0]                            mode,
    input  logic signed [31:0]                    operand_a,
    input  logic signed [31:0]                    operand_b,
    output fpa_pkg::fpa_tag_t                     tag_out,
    output logic [32+FRAC_BITS-1:0]               num_out,
    output logic [31:0]                           den_out
);
    import fpa_pkg::*;

    localparam int NUM_W = 32 + FRAC_BITS;

    logic signed [32:0] sum_w;
    logic signed [32:0] dif_w;
    logic signed [32:0] inc_w;
    logic signed [32:0] dec_w;
    logic signed [63:0] prod_w;
    logic signed [63:0] prod_sh;
    logic signed [63:0] from_w;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    fpa_res_t           res;
    logic               is_div;

    // Wide results; overflow is when the upper bits do not sign-extend bit 31.
    always_comb begin
        sum_w   = {operand_a[31], operand_a} + {operand_b[31], operand_b};
        dif_w   = {operand_a[31], operand_a} - {operand_b[31], operand_b};
        inc_w   = {operand_a[31], operand_a} + 33'sd1;
        dec_w   = {operand_a[31], operand_a} - 33'sd1;
        prod_w  = 64'(operand_a) * 64'(operand_b);
        prod_sh = prod_w >>> FRAC_BITS;
        from_w  = 64'(operand_a) <<< FRAC_BITS;
        abs_a   = operand_a[31] ? 32'(-operand_a) : operand_a;
        abs_b   = operand_b[31] ? 32'(-operand_b) : operand_b;
        is_div  = 1'b0;

        res.a_greater = operand_a > operand_b;
        res.a_equal   = operand_a == operand_b;
        res.a_less    = operand_a < operand_b;
        res.result    = '0;
        res.status    = ST_OK;
        case (mode)
            MODE_ADD: begin
                res.result = sum_w[31:0];
                if (sum_w[32] != sum_w[31]) res.status = ST_OVF;
            end
            MODE_SUB: begin
                res.result = dif_w[31:0];
                if (dif_w[32] != dif_w[31]) res.status = ST_OVF;
            end
            MODE_MUL: begin
                res.result = prod_sh[31:0];
                if (prod_sh[63:31] != {33{prod_sh[31]}}) res.status = ST_OVF;
            end
            MODE_DIV: begin
                if (operand_b == 32'sd0) res.status = ST_DIVZ;
                else is_div = 1'b1;
            end
            MODE_MIN: res.result = res.a_less ? operand_a : operand_b;
            MODE_MAX: res.result = res.a_greater ? operand_a : operand_b;
            MODE_INC: begin
                res.result = inc_w[31:0];
                if (inc_w[32] != inc_w[31]) res.status = ST_OVF;
            end
            MODE_DEC: begin
                res.result = dec_w[31:0];
                if (dec_w[32] != dec_w[31]) res.status = ST_OVF;
            end
            MODE_TOI: res.result = 32'(operand_a >>> FRAC_BITS);
            MODE_FROMI: begin
                res.result = from_w[31:0];
                if (from_w[63:31] != {33{from_w[31]}}) res.status = ST_OVF;
            end
            default: res.result = '0;
        endcase
    end

    // Only the valid bit is reset; the data follows it into the chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_out.valid <= 1'b0;
        end else if (en) begin
            tag_out.valid <= in_valid;
        end
        if (en) begin
            tag_out.is_div <= is_div;
            tag_out.neg    <= operand_a[31] ^ operand_b[31];
            tag_out.res    <= res;
            num_out        <= {abs_a, {FRAC_BITS{1'b0}}};
            den_out        <= abs_b;
        end
    end

    `include "fixed_point_alu_assert.svh"
    `FPA_ASSERT_NEXT(a_front_div_zero, aclk, aresetn,
        en && in_valid && mode == MODE_DIV && operand_b == 32'sd0,
        tag_out.res.status == ST_DIVZ && !tag_out.is_div)
    `FPA_ASSERT_NEXT(a_front_flags, aclk, aresetn, en && in_valid,
        $onehot({tag_out.res.a_greater, tag_out.res.a_equal, tag_out.res.a_less}))
    `FPA_ASSERT_IMPL(a_front_num_w, aclk, aresetn, 1'b1, $bits(num_out) == NUM_W)

endmodule

// File: rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// The block takes one word per cycle and returns one result word per input
// word, in order. Every word passes through the same pipeline: one front
// stage that does all non-divide operations and the compares, then a chain
// of 32+FRAC_BITS restoring-division cells (one quotient bit per cell), then
// a sign-fix and overflow check feeding an output register. Throughput is
// one word per cycle. The whole pipeline stalls while the output register
// holds a word not taken.
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[3:0], operand_a[35:4], operand_b[67:36], zero fill to 72 bits
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result[31:0], a_greater[32], a_equal[33], a_less[34], status[36:35]
    output logic [39:0] m_tdata
);
    import fpa_pkg::*;

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int DEN_W = 32;

    logic en;
    logic out_valid_reg;
    logic [39:0] out_data_reg;

    fpa_tag_t          tags [0:NUM_W];
    logic [NUM_W-1:0]  nums [0:NUM_W];
    logic [DEN_W-1:0]  dens [0:NUM_W];
    logic [DEN_W:0]    rems [0:NUM_W];
    logic [NUM_W-1:0]  quos [0:NUM_W];

    logic [NUM_W:0]    qs;
    logic [NUM_W:0]    q_mag_ext;
    fpa_res_t          fin;

    // Pipeline advances whenever the output slot is free or being emptied.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .mode      (s_tdata[3:0]),
        .operand_a (s_tdata[35:4]),
        .operand_b (s_tdata[67:36]),
        .tag_out   (tags[0]),
        .num_out   (nums[0]),
        .den_out   (dens[0])
    );

    assign rems[0] = '0;
    assign quos[0] = '0;

    // Chain of division cells.
    for (genvar i = 0; i < NUM_W; i++) begin : g_cell
        fpa_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .tag_in  (tags[i]),
            .num_in  (nums[i]),
            .den_in  (dens[i]),
            .rem_in  (rems[i]),
            .quo_in  (quos[i]),
            .tag_out (tags[i+1]),
            .num_out (nums[i+1]),
            .den_out (dens[i+1]),
            .rem_out (rems[i+1]),
            .quo_out (quos[i+1])
        );
    end

    // Apply the sign to the quotient and check it fits 32 signed bits.
    always_comb begin
        q_mag_ext = {1'b0, quos[NUM_W]};
        qs        = tags[NUM_W].neg ? (NUM_W+1)'(-q_mag_ext) : q_mag_ext;
        fin       = tags[NUM_W].res;
        if (tags[NUM_W].is_div) begin
            fin.result = qs[31:0];
            fin.status = (qs[NUM_W:31] != {(NUM_W-30){qs[31]}}) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= tags[NUM_W].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {3'b000, fin.status, fin.a_less, fin.a_equal,
                             fin.a_greater, fin.result};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `include "fixed_point_alu_assert.svh"
    `FPA_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
    `FPA_ASSERT_IMPL(a_ready, aclk, aresetn, !m_tvalid, s_tready)
    `FPA_ASSERT_IMPL(a_pad, aclk, aresetn, m_tvalid, m_tdata[39:37] == 3'b000)

endmodule
